### src/rpc_pkg.sv
package rpc_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int ZFRAC           = 20;
    localparam int VSHIFT          = 59 - COORD_WIDTH;
    localparam int ITERS           = 24;
    localparam int ZSTEP           = ZFRAC - ANGLE_FRAC_BITS;
    localparam int SQ_STEPS        = COORD_WIDTH;
    localparam int VW              = 64;
    localparam int ZW              = 32;
    localparam int SQW             = 2 * COORD_WIDTH;
    localparam int KSH_L           = (VSHIFT > 32) ? VSHIFT - 32 : 0;
    localparam int KSH_R           = (VSHIFT > 32) ? 0 : 32 - VSHIFT;

    localparam logic [31:0]          KINV_Q32  = 32'd2608131496;
    localparam logic signed [ZW-1:0] DEG90     = ZW'(90) <<< ZFRAC;
    localparam logic signed [ZW-1:0] DEG180    = ZW'(180) <<< ZFRAC;
    localparam logic signed [ZW-1:0] ANGLE_LIM = ZW'(180) <<< ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] RADIUS_MAX = ZW'(65535);

    // atan(2^-i) in units of 2^-20 degree.
    localparam logic signed [ZW-1:0] ATAN_TAB [ITERS] = '{
        32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
        32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
        32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
        32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
        32'sd917,      32'sd458,      32'sd229,      32'sd115,
        32'sd57,       32'sd29,       32'sd14,       32'sd7
    };

    typedef struct packed {
        logic                    mode;
        logic                    origin;
        logic signed [VW-1:0]    vx;
        logic signed [VW-1:0]    vy;
        logic signed [ZW-1:0]    z;
        logic [SQW-1:0]          sq_rem;
        logic [SQW-1:0]          sq_root;
    } t_item;

endpackage

### src/rect_polar_converter.sv
// Fully pipelined: one item can be accepted every clock cycle.
// The o_valid strobe for an item accepted on start passes the input register, the queue,
// the stage entry register, 24 CORDIC stages and the output register.
// busy rises only if the queue fills, which cannot happen since results never stall.
// Synchronous active-low reset clears all valid bits; no result is lost or repeated.
module rect_polar_converter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_mode,
    input  logic signed [15:0]  i_coord_x,
    input  logic signed [15:0]  i_coord_y,
    input  logic [15:0]         i_in_radius,
    input  logic signed [15:0]  i_in_angle,
    output logic                o_valid,
    output logic                o_out_mode,
    output logic signed [16:0]  o_out_x,
    output logic signed [16:0]  o_out_y,
    output logic [15:0]         o_out_radius,
    output logic signed [15:0]  o_out_angle
);
    import rpc_pkg::*;

    logic   q_full;
    logic   push;
    logic   q_vld;
    t_item  f_item;
    t_item  q_item;

    rpc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .i_in_radius (i_in_radius),
        .i_in_angle  (i_in_angle),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_item      (f_item)
    );

    rpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_item  (q_item)
    );

    rpc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (q_vld),
        .i_item       (q_item),
        .o_valid      (o_valid),
        .o_out_mode   (o_out_mode),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_radius (o_out_radius),
        .o_out_angle  (o_out_angle)
    );

endmodule

### src/rpc_front.sv
module rpc_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_mode,
    input  logic signed [15:0]                 i_coord_x,
    input  logic signed [15:0]                 i_coord_y,
    input  logic [15:0]                        i_in_radius,
    input  logic signed [15:0]                 i_in_angle,
    input  logic                               i_q_full,
    output logic                               o_push,
    output rpc_pkg::t_item                     o_item
);
    import rpc_pkg::*;

    logic                    r_a_vld;
    logic                    r_a_mode;
    logic signed [15:0]      r_a_x;
    logic signed [15:0]      r_a_y;
    logic [15:0]             r_a_r;
    logic signed [15:0]      r_a_ang;

    logic                    accept;
    logic [16:0]             ux, uy;
    logic [SQW-1:0]          sq;
    logic [47:0]             prod;
    logic [VW-1:0]           x0u;
    logic signed [VW-1:0]    x0, px, py;
    logic signed [ZW-1:0]    za;
    t_item                   n_item;

    assign busy   = r_a_vld && i_q_full;
    assign accept = start && !busy;
    assign o_push = r_a_vld && !i_q_full;
    assign o_item = n_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (accept) begin
            r_a_vld <= 1'b1;
        end else if (o_push) begin
            r_a_vld <= 1'b0;
        end
        if (accept) begin
            r_a_mode <= i_mode;
            r_a_x    <= i_coord_x;
            r_a_y    <= i_coord_y;
            r_a_r    <= i_in_radius;
            r_a_ang  <= i_in_angle;
        end
    end

    always_comb begin
        ux   = r_a_x[15] ? 17'(-{r_a_x[15], r_a_x}) : {1'b0, r_a_x};
        uy   = r_a_y[15] ? 17'(-{r_a_y[15], r_a_y}) : {1'b0, r_a_y};
        sq   = SQW'(ux) * SQW'(ux) + SQW'(uy) * SQW'(uy);
        prod = 48'(r_a_r) * 48'(KINV_Q32);
        x0u  = (VW'(prod) << KSH_L) >> KSH_R;
        x0   = signed'(x0u);
        px   = VW'(r_a_x) <<< VSHIFT;
        py   = VW'(r_a_y) <<< VSHIFT;
        za   = ZW'(r_a_ang) <<< ZSTEP;

        n_item         = '0;
        n_item.mode    = r_a_mode;
        n_item.sq_rem  = sq;
        n_item.sq_root = '0;
        if (!r_a_mode) begin
            n_item.origin = (r_a_x == 16'sd0) && (r_a_y == 16'sd0);
            n_item.vx     = px;
            n_item.vy     = py;
            n_item.z      = '0;
            if (r_a_x < 16'sd0) begin
                if (r_a_y >= 16'sd0) begin
                    n_item.vx = py;
                    n_item.vy = -px;
                    n_item.z  = DEG90;
                end else begin
                    n_item.vx = -py;
                    n_item.vy = px;
                    n_item.z  = -DEG90;
                end
            end
        end else begin
            // The input angle spans less than two turns, so one wrap suffices.
            if (za > DEG180) begin
                za = za - (DEG180 <<< 1);
            end else if (za < -DEG180) begin
                za = za + (DEG180 <<< 1);
            end
            n_item.vx = x0;
            n_item.vy = '0;
            n_item.z  = za;
            if (za > DEG90) begin
                n_item.vx = '0;
                n_item.vy = x0;
                n_item.z  = za - DEG90;
            end else if (za < -DEG90) begin
                n_item.vx = '0;
                n_item.vy = -x0;
                n_item.z  = za + DEG90;
            end
        end
    end

endmodule

### src/rpc_queue.sv
module rpc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rpc_pkg::t_item  i_item,
    output logic            o_full,
    output logic            o_vld,
    output rpc_pkg::t_item  o_item
);
    import rpc_pkg::*;

    t_item       r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        pop;

    assign o_full = (r_cnt == 2'd2);
    assign o_vld  = (r_cnt != 2'd0);
    assign o_item = r_mem[r_rp];
    // The back end never stalls, so the head leaves every cycle it is valid.
    assign pop    = o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("transfer into a full queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");

endmodule

### src/rpc_back.sv
module rpc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  rpc_pkg::t_item      i_item,
    output logic                o_valid,
    output logic                o_out_mode,
    output logic signed [16:0]  o_out_x,
    output logic signed [16:0]  o_out_y,
    output logic [15:0]         o_out_radius,
    output logic signed [15:0]  o_out_angle
);
    import rpc_pkg::*;

    logic                r_vld [ITERS+1];
    t_item               r_st  [ITERS+1];

    logic                r_valid;
    logic                r_out_mode;
    logic signed [16:0]  r_out_x;
    logic signed [16:0]  r_out_y;
    logic [15:0]         r_out_radius;
    logic signed [15:0]  r_out_angle;

    t_item                   fin;
    logic signed [ZW-1:0]    ang;
    logic [SQW-1:0]          root;
    logic signed [VW-1:0]    xr, yr;
    logic                    n_valid;
    logic signed [16:0]      n_out_x, n_out_y;
    logic [15:0]             n_out_radius;
    logic signed [15:0]      n_out_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
        r_st[0] <= i_item;
    end

    for (genvar i = 0; i < ITERS; i++) begin : g_stage
        t_item                 n_st;
        logic signed [VW-1:0]  dx, dy;
        logic                  cw;
        logic [SQW-1:0]        bitv;
        logic [SQW:0]          trial;

        always_comb begin
            n_st  = r_st[i];
            dx    = r_st[i].vx >>> i;
            dy    = r_st[i].vy >>> i;
            cw    = r_st[i].mode ? (r_st[i].z < 0) : (r_st[i].vy >= 0);
            if (cw) begin
                n_st.vx = r_st[i].vx + dy;
                n_st.vy = r_st[i].vy - dx;
                n_st.z  = r_st[i].z + ATAN_TAB[i];
            end else begin
                n_st.vx = r_st[i].vx - dy;
                n_st.vy = r_st[i].vy + dx;
                n_st.z  = r_st[i].z - ATAN_TAB[i];
            end
            bitv  = '0;
            trial = '0;
            // One bit of the integer square root per stage, in the first stages.
            if (i < SQ_STEPS) begin
                bitv  = SQW'(1) << (SQW - 2 - 2 * i);
                trial = {1'b0, r_st[i].sq_root} + {1'b0, bitv};
                if ({1'b0, r_st[i].sq_rem} >= trial) begin
                    n_st.sq_rem  = r_st[i].sq_rem - trial[SQW-1:0];
                    n_st.sq_root = (r_st[i].sq_root >> 1) + bitv;
                end else begin
                    n_st.sq_root = r_st[i].sq_root >> 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else begin
                r_vld[i+1] <= r_vld[i];
            end
            r_st[i+1] <= n_st;
        end
    end

    always_comb begin
        fin          = r_st[ITERS];
        n_valid      = r_vld[ITERS];
        n_out_x      = '0;
        n_out_y      = '0;
        n_out_radius = '0;
        n_out_angle  = '0;
        ang          = '0;
        root         = '0;
        xr           = '0;
        yr           = '0;
        if (!fin.mode) begin
            root = fin.sq_root + SQW'(fin.sq_rem > fin.sq_root);
            n_out_radius = (root > SQW'(RADIUS_MAX)) ? 16'hFFFF : root[15:0];
            if (!fin.origin) begin
                ang = (fin.z + (ZW'(1) <<< (ZSTEP - 1))) >>> ZSTEP;
                if (ang > ANGLE_LIM) begin
                    ang = ANGLE_LIM;
                end else if (ang < -ANGLE_LIM) begin
                    ang = -ANGLE_LIM;
                end
                n_out_angle = ang[15:0];
            end
        end else begin
            xr = (fin.vx + (VW'(1) <<< (VSHIFT - 1))) >>> VSHIFT;
            yr = (fin.vy + (VW'(1) <<< (VSHIFT - 1))) >>> VSHIFT;
            if (xr > VW'(RADIUS_MAX)) begin
                xr = VW'(RADIUS_MAX);
            end else if (xr < -VW'(RADIUS_MAX)) begin
                xr = -VW'(RADIUS_MAX);
            end
            if (yr > VW'(RADIUS_MAX)) begin
                yr = VW'(RADIUS_MAX);
            end else if (yr < -VW'(RADIUS_MAX)) begin
                yr = -VW'(RADIUS_MAX);
            end
            n_out_x = xr[16:0];
            n_out_y = yr[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_out_mode   <= fin.mode;
        r_out_x      <= n_out_x;
        r_out_y      <= n_out_y;
        r_out_radius <= n_out_radius;
        r_out_angle  <= n_out_angle;
    end

    assign o_valid      = r_valid;
    assign o_out_mode   = r_out_mode;
    assign o_out_x      = r_out_x;
    assign o_out_y      = r_out_y;
    assign o_out_radius = r_out_radius;
    assign o_out_angle  = r_out_angle;

    a_polar_zero_xy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_out_mode |-> r_out_x == 17'sd0 && r_out_y == 17'sd0)
        else $error("x or y set on a polar result");
    a_rect_zero_ra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_out_mode |-> r_out_radius == 16'd0 && r_out_angle == 16'sd0)
        else $error("radius or angle set on a rectangular result");
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ZW'(r_out_angle) <= ANGLE_LIM && ZW'(r_out_angle) >= -ANGLE_LIM)
        else $error("angle out of range");

endmodule

### sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rpc_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic               mode;
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic [15:0]        radius;
        logic signed [15:0] angle;
    } conv_result_t;

    class conv_scoreboard;
        conv_result_t pending_conv[$];
        int           mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Rounded integer square root, digit by digit.
        function longint unsigned rounded_sqrt(longint unsigned s);
            longint unsigned root;
            longint unsigned bit_w;
            root  = 0;
            bit_w = 64'd1 << 62;
            while (bit_w > s) bit_w = bit_w >> 2;
            while (bit_w != 0) begin
                if (s >= root + bit_w) begin
                    s    = s - (root + bit_w);
                    root = (root >> 1) + bit_w;
                end else begin
                    root = root >> 1;
                end
                bit_w = bit_w >> 2;
            end
            if (s > root) root++;
            return root;
        endfunction

        function longint saturate_coord(longint v);
            if (v > 65535) return 65535;
            if (v < -65535) return -65535;
            return v;
        endfunction

        function conv_result_t convert(logic m, logic signed [15:0] cx,
                                       logic signed [15:0] cy, logic [15:0] rr,
                                       logic signed [15:0] aa);
            conv_result_t    res;
            longint          x, y, vx, vy, z, dx, dy, t, oa, x0, lim;
            longint unsigned ux, uy, rad, prod;
            longint          deg90, deg180;
            deg90  = longint'(90) <<< ZFRAC;
            deg180 = longint'(180) <<< ZFRAC;
            res.mode   = m;
            res.x      = '0;
            res.y      = '0;
            res.radius = '0;
            res.angle  = '0;
            if (m == 1'b0) begin
                x   = cx;
                y   = cy;
                ux  = (x < 0) ? -x : x;
                uy  = (y < 0) ? -y : y;
                rad = rounded_sqrt(ux * ux + uy * uy);
                if (rad > 65535) rad = 65535;
                res.radius = rad[15:0];
                if (x != 0 || y != 0) begin
                    vx = x <<< VSHIFT;
                    vy = y <<< VSHIFT;
                    z  = 0;
                    // Points left of the y axis are first turned by a quarter turn.
                    if (vx < 0) begin
                        t = vx;
                        if (vy >= 0) begin
                            vx = vy; vy = -t; z = deg90;
                        end else begin
                            vx = -vy; vy = t; z = -deg90;
                        end
                    end
                    for (int i = 0; i < ITERS; i++) begin
                        dx = vx >>> i;
                        dy = vy >>> i;
                        if (vy >= 0) begin
                            vx += dy; vy -= dx; z += longint'(ATAN_TAB[i]);
                        end else begin
                            vx -= dy; vy += dx; z -= longint'(ATAN_TAB[i]);
                        end
                    end
                    oa  = (z + (longint'(1) <<< (ZSTEP - 1))) >>> ZSTEP;
                    lim = longint'(180) <<< ANGLE_FRAC_BITS;
                    if (oa > lim) oa = lim;
                    if (oa < -lim) oa = -lim;
                    res.angle = oa[15:0];
                end
            end else begin
                z    = longint'(aa) <<< ZSTEP;
                prod = longint'(rr) * longint'(KINV_Q32);
                x0   = longint'(prod << KSH_L) >>> KSH_R;
                while (z > deg180) z -= 2 * deg180;
                while (z < -deg180) z += 2 * deg180;
                vx = x0;
                vy = 0;
                if (z > deg90) begin
                    vx = 0; vy = x0; z -= deg90;
                end else if (z < -deg90) begin
                    vx = 0; vy = -x0; z += deg90;
                end
                for (int i = 0; i < ITERS; i++) begin
                    dx = vx >>> i;
                    dy = vy >>> i;
                    if (z >= 0) begin
                        vx -= dy; vy += dx; z -= longint'(ATAN_TAB[i]);
                    end else begin
                        vx += dy; vy -= dx; z += longint'(ATAN_TAB[i]);
                    end
                end
                t     = saturate_coord((vx + (longint'(1) <<< (VSHIFT - 1))) >>> VSHIFT);
                res.x = t[16:0];
                t     = saturate_coord((vy + (longint'(1) <<< (VSHIFT - 1))) >>> VSHIFT);
                res.y = t[16:0];
            end
            return res;
        endfunction

        function void note_input(logic m, logic signed [15:0] cx, logic signed [15:0] cy,
                                 logic [15:0] rr, logic signed [15:0] aa);
            pending_conv.push_back(convert(m, cx, cy, rr, aa));
        endfunction

        function void report_error(string what);
            mismatches++;
            if (mismatches <= 10) $display("mismatch: %s", what);
        endfunction

        function void check_result(logic m, logic signed [16:0] ox, logic signed [16:0] oy,
                                   logic [15:0] orad, logic signed [15:0] oang);
            conv_result_t want;
            if (pending_conv.size() == 0) begin
                report_error("result with no transfer outstanding");
                return;
            end
            want = pending_conv.pop_front();
            if (m !== want.mode)
                report_error($sformatf("mode exp %0d got %0d", want.mode, m));
            if (ox !== want.x)
                report_error($sformatf("x exp %0d got %0d", want.x, ox));
            if (oy !== want.y)
                report_error($sformatf("y exp %0d got %0d", want.y, oy));
            if (orad !== want.radius)
                report_error($sformatf("radius exp %0d got %0d", want.radius, orad));
            if (oang !== want.angle)
                report_error($sformatf("angle exp %0d got %0d", want.angle, oang));
        endfunction

        function int outstanding();
            return pending_conv.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_mode;
    logic signed [15:0] i_coord_x;
    logic signed [15:0] i_coord_y;
    logic [15:0]        i_in_radius;
    logic signed [15:0] i_in_angle;
    logic               o_valid;
    logic               o_out_mode;
    logic signed [16:0] o_out_x;
    logic signed [16:0] o_out_y;
    logic [15:0]        o_out_radius;
    logic signed [15:0] o_out_angle;

    conv_scoreboard sb;
    int             cycles = 0;

    rect_polar_converter DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_in_radius  (i_in_radius),
        .i_in_angle   (i_in_angle),
        .o_valid      (o_valid),
        .o_out_mode   (o_out_mode),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_radius (o_out_radius),
        .o_out_angle  (o_out_angle)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Both transfers are taken from the values present at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            sb.note_input(i_mode, i_coord_x, i_coord_y, i_in_radius, i_in_angle);
        if (i_rst_n && o_valid)
            sb.check_result(o_out_mode, o_out_x, o_out_y, o_out_radius, o_out_angle);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_item(logic m, logic signed [15:0] cx, logic signed [15:0] cy,
                             logic [15:0] rr, logic signed [15:0] aa);
        start       <= 1'b1;
        i_mode      <= m;
        i_coord_x   <= cx;
        i_coord_y   <= cy;
        i_in_radius <= rr;
        i_in_angle  <= aa;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_random();
        logic               m;
        logic signed [15:0] cx, cy, aa;
        logic [15:0]        rr;
        m  = 1'($urandom_range(0, 1));
        cx = 16'($urandom);
        cy = 16'($urandom);
        rr = 16'($urandom);
        aa = 16'($urandom);
        // Bias some items toward small values and the legal angle range.
        case ($urandom_range(0, 3))
            0: begin
                cx = $signed(16'($urandom_range(0, 15))) - 16'sd8;
                cy = $signed(16'($urandom_range(0, 15))) - 16'sd8;
                rr = 16'($urandom_range(0, 100));
            end
            1: begin
                aa = $signed(16'($urandom_range(0, 46080))) - 16'sd23040;
                rr = 16'($urandom_range(0, 46341));
            end
            default: ;
        endcase
        send_item(m, cx, cy, rr, aa);
    endtask

    initial begin
        int sent;
        int burst;
        sb          = new();
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_mode      = 1'b0;
        i_coord_x   = '0;
        i_coord_y   = '0;
        i_in_radius = '0;
        i_in_angle  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Origin, the negative x axis, the corners and the axes.
        send_item(1'b0, 16'sd0, 16'sd0, 16'hFFFF, 16'sd5);
        send_item(1'b0, -16'sd1, 16'sd0, 16'd0, 16'sd0);
        send_item(1'b0, -16'sd32768, 16'sd0, 16'd0, 16'sd0);
        send_item(1'b0, 16'sd32767, 16'sd0, 16'd0, 16'sd0);
        send_item(1'b0, 16'sd0, -16'sd32768, 16'd0, 16'sd0);
        send_item(1'b0, 16'sd0, 16'sd32767, 16'd0, 16'sd0);
        send_item(1'b0, -16'sd32768, -16'sd32768, 16'd0, 16'sd0);
        send_item(1'b0, 16'sd32767, 16'sd32767, 16'd0, 16'sd0);
        send_item(1'b0, -16'sd32768, 16'sd32767, 16'd0, 16'sd0);
        send_item(1'b0, -16'sd5, -16'sd1, 16'd0, 16'sd0);
        // Polar input: angle limits, wrapping beyond a half turn, large radii.
        send_item(1'b1, 16'sd0, 16'sd0, 16'd0, 16'sd0);
        send_item(1'b1, 16'sd0, 16'sd0, 16'd46341, -16'sd23040);
        send_item(1'b1, 16'sd0, 16'sd0, 16'd46341, 16'sd23040);
        send_item(1'b1, 16'sd0, 16'sd0, 16'd65535, 16'sd32767);
        send_item(1'b1, 16'sd0, 16'sd0, 16'd65535, -16'sd32768);
        send_item(1'b1, 16'sd0, 16'sd0, 16'd65535, 16'sd0);
        send_item(1'b1, 16'sd0, 16'sd0, 16'd65535, 16'sd11520);
        send_item(1'b1, 16'sd0, 16'sd0, 16'd1000, -16'sd11520);
        send_item(1'b1, -16'sd1, -16'sd1, 16'd1, 16'sd5760);
        idle_cycles(3);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                send_random();
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 8));
            if (sent >= RANDOM_ITEMS / 2 && sent < RANDOM_ITEMS / 2 + burst) begin
                // Let the pipeline empty completely once mid-run.
                start <= 1'b0;
                while (sb.outstanding() != 0) @(posedge i_clk);
            end
        end
        start <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### filelist.f
src/rpc_pkg.sv
src/rpc_front.sv
src/rpc_queue.sv
src/rpc_back.sv
src/rect_polar_converter.sv
sim/tb_top.sv
